// ===== sv/tisp_pkg.sv =====
`default_nettype none
package tisp_pkg;

	localparam logic [7:0] ByteIac   = 8'd255;
	localparam logic [7:0] ByteDont  = 8'd254;
	localparam logic [7:0] ByteDo    = 8'd253;
	localparam logic [7:0] ByteWont  = 8'd252;
	localparam logic [7:0] ByteWill  = 8'd251;
	localparam logic [7:0] ByteSb    = 8'd250;
	localparam logic [7:0] ByteSe    = 8'd240;
	localparam logic [7:0] ByteTtype = 8'd24;
	localparam logic [7:0] ByteSga   = 8'd3;
	localparam logic [7:0] ByteSend  = 8'd1;
	localparam logic [7:0] ByteIs    = 8'd0;

	localparam int CmdDepth = 4;

	localparam logic [3:0] LenData  = 4'd1;
	localparam logic [3:0] LenNeg   = 4'd3;
	localparam logic [3:0] LenTtype = 4'd11;

	typedef enum logic [3:0] {
		ST_DATA     = 4'd0,
		ST_IAC      = 4'd1,
		ST_OPT_DO   = 4'd2,
		ST_OPT_DONT = 4'd3,
		ST_OPT_WILL = 4'd4,
		ST_OPT_WONT = 4'd5,
		ST_SB_OPT   = 4'd6,
		ST_SB_SEND  = 4'd7,
		ST_SB_BODY  = 4'd8,
		ST_SB_IAC   = 4'd9
	} parse_state_t;

	typedef enum logic [1:0] {
		CMD_DATA  = 2'd0,
		CMD_NEG   = 2'd1,
		CMD_TTYPE = 2'd2
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] code;
		logic [7:0] value;
	} cmd_t;

	function automatic logic [7:0] ttype_reply_byte(input logic [3:0] idx);
		logic [7:0] b;
		unique case (idx)
			4'd0:    b = ByteIac;
			4'd1:    b = ByteSb;
			4'd2:    b = ByteTtype;
			4'd3:    b = ByteIs;
			4'd4:    b = 8'h56;
			4'd5:    b = 8'h54;
			4'd6:    b = 8'h31;
			4'd7:    b = 8'h30;
			4'd8:    b = 8'h30;
			4'd9:    b = ByteIac;
			4'd10:   b = ByteSe;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

	function automatic logic [3:0] cmd_len(input cmd_kind_t kind);
		logic [3:0] n;
		unique case (kind)
			CMD_DATA:  n = LenData;
			CMD_NEG:   n = LenNeg;
			CMD_TTYPE: n = LenTtype;
			default:   n = LenData;
		endcase
		return n;
	endfunction

endpackage
`default_nettype wire

// ===== sv/telnet_iac_stream_parser_top.sv =====
`default_nettype none
// A data byte goes through the command queue, then the registered output stage.
// Throughput: one received byte per cycle while full is low; a negotiation reply
// is three bytes, a terminal-type reply eleven, emitted one per cycle unless held.
// While the emitter works off a reply, the command queue absorbs up to CmdDepth
// commands; then full rises until a slot frees.
// Reset (arst_n low, asynchronous): parser to plain data, queue and output emptied.
module telnet_iac_stream_parser_top #(
	parameter int CmdDepth = tisp_pkg::CmdDepth
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] rx_byte,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       to_network,
	output logic       last
);

	logic           accept;
	logic           front_valid;
	tisp_pkg::cmd_t front_cmd;
	logic           head_valid;
	tisp_pkg::cmd_t head_cmd;
	logic           head_pop;
	logic           taken;

	// An input transaction advances the parser; bytes that make no result
	// are still held off while the queue is full, which keeps the control simple.
	assign accept = push && !full;
	assign taken  = pop && !empty;

	// Front: track IAC / option / subnegotiation state, classify each byte.
	tisp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.rx_byte   (rx_byte),
		.cmd_valid (front_valid),
		.cmd       (front_cmd)
	);

	// Queue between parser and emitter, so each side can stall on its own.
	tisp_cmd_fifo #(
		.Depth (CmdDepth)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && front_valid),
		.wr_cmd   (front_cmd),
		.full     (full),
		.rd_en    (head_pop),
		.rd_valid (head_valid),
		.rd_cmd   (head_cmd)
	);

	// Back: expand each command into its result bytes, one per cycle unless the
	// output is held, through a registered output stage.
	tisp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (head_valid),
		.cmd        (head_cmd),
		.cmd_pop    (head_pop),
		.empty      (empty),
		.pop        (taken),
		.out_byte   (out_byte),
		.to_network (to_network),
		.last       (last)
	);

endmodule
`default_nettype wire

// ===== sv/tisp_front.sv =====
`default_nettype none
module tisp_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        rx_byte,
	output logic              cmd_valid,
	output tisp_pkg::cmd_t    cmd
);

	tisp_pkg::parse_state_t state_q, state_d;
	logic ttype_seen_q, ttype_seen_d;

	// next state
	always_comb begin
		state_d      = state_q;
		ttype_seen_d = ttype_seen_q;
		unique case (state_q)
			tisp_pkg::ST_IAC: begin
				priority if (rx_byte == tisp_pkg::ByteDo) begin
					state_d = tisp_pkg::ST_OPT_DO;
				end else if (rx_byte == tisp_pkg::ByteDont) begin
					state_d = tisp_pkg::ST_OPT_DONT;
				end else if (rx_byte == tisp_pkg::ByteWill) begin
					state_d = tisp_pkg::ST_OPT_WILL;
				end else if (rx_byte == tisp_pkg::ByteWont) begin
					state_d = tisp_pkg::ST_OPT_WONT;
				end else if (rx_byte == tisp_pkg::ByteSb) begin
					ttype_seen_d = 1'b0;
					state_d      = tisp_pkg::ST_SB_OPT;
				end else begin
					state_d = tisp_pkg::ST_DATA;
				end
			end
			tisp_pkg::ST_OPT_DO, tisp_pkg::ST_OPT_WILL,
			tisp_pkg::ST_OPT_DONT, tisp_pkg::ST_OPT_WONT: begin
				state_d = tisp_pkg::ST_DATA;
			end
			tisp_pkg::ST_SB_OPT: begin
				priority if (rx_byte == tisp_pkg::ByteIac) begin
					state_d = tisp_pkg::ST_SB_IAC;
				end else if (rx_byte == tisp_pkg::ByteTtype) begin
					state_d = tisp_pkg::ST_SB_SEND;
				end else begin
					state_d = tisp_pkg::ST_SB_BODY;
				end
			end
			tisp_pkg::ST_SB_SEND: begin
				if (rx_byte == tisp_pkg::ByteIac) begin
					state_d = tisp_pkg::ST_SB_IAC;
				end else begin
					if (rx_byte == tisp_pkg::ByteSend) begin
						ttype_seen_d = 1'b1;
					end
					state_d = tisp_pkg::ST_SB_BODY;
				end
			end
			tisp_pkg::ST_SB_BODY: begin
				if (rx_byte == tisp_pkg::ByteIac) begin
					state_d = tisp_pkg::ST_SB_IAC;
				end
			end
			tisp_pkg::ST_SB_IAC: begin
				if (rx_byte == tisp_pkg::ByteSe) begin
					ttype_seen_d = 1'b0;
					state_d      = tisp_pkg::ST_DATA;
				end else begin
					state_d = tisp_pkg::ST_SB_BODY;
				end
			end
			default: begin
				state_d = (rx_byte == tisp_pkg::ByteIac) ? tisp_pkg::ST_IAC : tisp_pkg::ST_DATA;
			end
		endcase
	end

	// classify the byte into a command for the back end
	always_comb begin
		cmd_valid  = 1'b0;
		cmd.kind   = tisp_pkg::CMD_DATA;
		cmd.code   = rx_byte;
		cmd.value  = rx_byte;
		unique case (state_q)
			tisp_pkg::ST_IAC: begin
				cmd_valid = (rx_byte == tisp_pkg::ByteIac);
			end
			tisp_pkg::ST_OPT_DO: begin
				cmd_valid = 1'b1;
				cmd.kind  = tisp_pkg::CMD_NEG;
				cmd.code  = (rx_byte == tisp_pkg::ByteSga || rx_byte == tisp_pkg::ByteTtype)
					? tisp_pkg::ByteWill : tisp_pkg::ByteWont;
			end
			tisp_pkg::ST_OPT_WILL: begin
				cmd_valid = 1'b1;
				cmd.kind  = tisp_pkg::CMD_NEG;
				cmd.code  = tisp_pkg::ByteDont;
			end
			tisp_pkg::ST_OPT_DONT, tisp_pkg::ST_OPT_WONT, tisp_pkg::ST_SB_OPT,
			tisp_pkg::ST_SB_SEND, tisp_pkg::ST_SB_BODY: begin
				cmd_valid = 1'b0;
			end
			tisp_pkg::ST_SB_IAC: begin
				cmd_valid = (rx_byte == tisp_pkg::ByteSe) && ttype_seen_q;
				cmd.kind  = tisp_pkg::CMD_TTYPE;
			end
			default: begin
				cmd_valid = (rx_byte != tisp_pkg::ByteIac);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= tisp_pkg::ST_DATA;
			ttype_seen_q <= 1'b0;
		end else if (accept) begin
			state_q      <= state_d;
			ttype_seen_q <= ttype_seen_d;
		end
	end

endmodule
`default_nettype wire

// ===== sv/tisp_cmd_fifo.sv =====
`default_nettype none
module tisp_cmd_fifo #(
	parameter int Depth = tisp_pkg::CmdDepth
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  tisp_pkg::cmd_t wr_cmd,
	output logic           full,
	input  logic           rd_en,
	output logic           rd_valid,
	output tisp_pkg::cmd_t rd_cmd
);

	localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntW  = $clog2(Depth + 1);
	localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
	localparam logic [CntW-1:0]  DepthCnt = CntW'(Depth);

	tisp_pkg::cmd_t    mem_q [Depth];
	logic [AddrW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0]   count_q;

	assign full     = (count_q == DepthCnt);
	assign rd_valid = (count_q != '0);
	assign rd_cmd   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + AddrW'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + AddrW'(1);
			end
			unique case ({wr_en, rd_en})
				2'b10:   count_q <= count_q + CntW'(1);
				2'b01:   count_q <= count_q - CntW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/tisp_back.sv =====
`default_nettype none
module tisp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  tisp_pkg::cmd_t cmd,
	output logic           cmd_pop,
	output logic           empty,
	input  logic           pop,
	output logic [7:0]     out_byte,
	output logic           to_network,
	output logic           last
);

	logic [3:0] idx_q;
	logic [3:0] len;
	logic       last_el;
	logic       load;
	logic [7:0] sel_byte;
	logic       valid_q;
	logic [7:0] byte_q;
	logic       net_q;
	logic       last_q;

	assign len     = tisp_pkg::cmd_len(cmd.kind);
	assign last_el = (idx_q == len - 4'd1);
	assign load    = cmd_valid && (!valid_q || pop);
	assign cmd_pop = load && last_el;

	always_comb begin
		unique case (cmd.kind)
			tisp_pkg::CMD_NEG: begin
				unique case (idx_q)
					4'd0:    sel_byte = tisp_pkg::ByteIac;
					4'd1:    sel_byte = cmd.code;
					default: sel_byte = cmd.value;
				endcase
			end
			tisp_pkg::CMD_TTYPE: sel_byte = tisp_pkg::ttype_reply_byte(idx_q);
			default:             sel_byte = cmd.value;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q   <= last_el ? 4'd0 : idx_q + 4'd1;
				valid_q <= 1'b1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			byte_q <= sel_byte;
			net_q  <= (cmd.kind != tisp_pkg::CMD_DATA);
			last_q <= last_el;
		end
	end

	assign empty      = !valid_q;
	assign out_byte   = byte_q;
	assign to_network = net_q;
	assign last       = last_q;

`ifndef SYNTHESIS
	a_idx_needs_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(idx_q != 4'd0) |-> cmd_valid)
		else $error("reply index advanced with no command at the queue head");
	a_idx_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> (idx_q < len))
		else $error("reply index beyond command length");
	a_data_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !net_q) |-> last_q)
		else $error("terminal data byte not marked last");
	a_pop_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		(load && last_el) |=> (idx_q == 4'd0))
		else $error("index not rewound after final reply byte");
`endif

endmodule
`default_nettype wire
